@@ hw/rtl/sng_pkg.sv @@
`default_nettype none

package sng_pkg;

  // longest name that still counts as valid
  localparam int unsigned MaxNameLen = 255;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [7:0] TILDE_CHAR = 8'h7E;
  localparam logic [7:0] ONE_CHAR   = 8'h31;

  // short name positions
  localparam logic [3:0] IDX_TILDE = 4'd6;
  localparam logic [3:0] IDX_ONE   = 4'd7;
  localparam logic [3:0] IDX_EXT   = 4'd8;
  localparam logic [3:0] IDX_LAST  = 4'd10;

  localparam int unsigned BaseLen = 8;
  localparam int unsigned ExtLen  = 3;

  typedef struct packed {
    logic capture;  // take one name byte
    logic load;     // put next short name byte in the output register
    logic clear;    // name done, return to empty state
  } sng_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic index_last;
  } sng_stat_t;

  function automatic logic is_forbidden(input logic [7:0] b);
    logic bad;
    bad = 1'b0;
    if (b < SPACE_CHAR) begin
      bad = 1'b1;
    end
    case (b) inside
      8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2F,
      8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
      8'h5B, 8'h5C, 8'h5D, 8'h7C: bad = 1'b1;
      default: ;
    endcase
    return bad;
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sng_ctrl.sv @@
`default_nettype none

module sng_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic             s_tlast,
  input  wire logic             m_tready,
  input  wire sng_pkg::sng_stat_t stat,
  output      logic             s_tready,
  output      sng_pkg::sng_cmd_t cmd
);

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_EMIT    = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    cmd.capture = (state == ST_COLLECT) && s_tvalid;
    cmd.load    = (state == ST_EMIT) && (!stat.out_valid || m_tready);
    cmd.clear   = cmd.load && stat.index_last;
    s_tready    = (state == ST_COLLECT);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (cmd.capture && s_tlast) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd.clear) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sng_datapath.sv @@
`default_nettype none

module sng_datapath #(
  parameter int unsigned MAX_NAME_LEN = sng_pkg::MaxNameLen
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sng_pkg::sng_cmd_t cmd,
  input  wire logic              m_tready,
  input  wire logic [7:0]        name_byte,
  output      sng_pkg::sng_stat_t stat,
  output      logic [7:0]        short_byte,
  output      logic [3:0]        byte_index,
  output      logic [7:0]        name_checksum,
  output      logic              name_ok,
  output      logic              final_result,
  output      logic              out_valid
);

  localparam int unsigned CountSat = MAX_NAME_LEN + 1;
  localparam int unsigned CntW     = $clog2(MAX_NAME_LEN + 2);

  logic [7:0]      base_store [sng_pkg::BaseLen];
  logic [7:0]      tail_store [sng_pkg::ExtLen];
  logic [1:0]      tail_count;
  logic [CntW-1:0] byte_count;
  logic [CntW-1:0] dot_position;
  logic            dot_seen;
  logic            bad_byte_seen;
  logic [3:0]      emit_index;
  logic [7:0]      sum;

  logic [CntW-1:0] ext_pos;
  logic [7:0]      sfn_byte;
  logic [7:0]      sum_next;
  logic [1:0]      tail_sel;
  logic            ok_now;

  assign tail_sel = emit_index[1:0];

  // short name byte for the current position
  always_comb begin
    ext_pos  = dot_seen ? dot_position : byte_count;
    sfn_byte = sng_pkg::SPACE_CHAR;
    if (emit_index < sng_pkg::IDX_EXT) begin
      if (ext_pos > CntW'(sng_pkg::BaseLen) && emit_index == sng_pkg::IDX_TILDE) begin
        sfn_byte = sng_pkg::TILDE_CHAR;
      end else if (ext_pos > CntW'(sng_pkg::BaseLen) && emit_index == sng_pkg::IDX_ONE) begin
        sfn_byte = sng_pkg::ONE_CHAR;
      end else if (CntW'(emit_index) < ext_pos) begin
        sfn_byte = sng_pkg::fold_upper(base_store[emit_index[2:0]]);
      end
    end else if (tail_sel != 2'd3 && tail_sel < tail_count) begin
      sfn_byte = sng_pkg::fold_upper(tail_store[tail_sel]);
    end
    sum_next = {sum[0], sum[7:1]} + sfn_byte;
    ok_now   = (byte_count <= CntW'(MAX_NAME_LEN)) && !bad_byte_seen;
  end

  assign stat.out_valid  = out_valid;
  assign stat.index_last = (emit_index == sng_pkg::IDX_LAST);

  // name state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      tail_count    <= '0;
      byte_count    <= '0;
      dot_position  <= '0;
      dot_seen      <= 1'b0;
      bad_byte_seen <= 1'b0;
      emit_index    <= '0;
      sum           <= '0;
    end else begin
      if (cmd.capture) begin
        if (sng_pkg::is_forbidden(name_byte)) begin
          bad_byte_seen <= 1'b1;
        end
        if (name_byte == sng_pkg::DOT_CHAR) begin
          dot_seen     <= 1'b1;
          dot_position <= byte_count;
          tail_count   <= '0;
        end else if (dot_seen && tail_count != 2'd3) begin
          tail_count <= tail_count + 2'd1;
        end
        if (byte_count != CntW'(CountSat)) begin
          byte_count <= byte_count + CntW'(1);
        end
      end
      if (cmd.load) begin
        emit_index <= emit_index + 4'd1;
        sum        <= sum_next;
      end
    end
  end

  // byte stores, written in place
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      if (byte_count < CntW'(sng_pkg::BaseLen)) begin
        base_store[byte_count[2:0]] <= name_byte;
      end
      if (name_byte != sng_pkg::DOT_CHAR && dot_seen && tail_count != 2'd3) begin
        tail_store[tail_count] <= name_byte;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      short_byte    <= sfn_byte;
      byte_index    <= emit_index;
      name_checksum <= stat.index_last ? sum_next : 8'h00;
      name_ok       <= ok_now;
      final_result  <= stat.index_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/short_name_generator_with_checksum_top.sv @@
// 8.3 short name generator: takes a long file name one byte per word on the
// slave stream (tlast on the final byte) and, after the final byte, sends the
// eleven bytes of the upper-cased short name on the master stream, base in
// positions 0 to 7 and extension in 8 to 10, with tlast on the eleventh word.
// that word also carries the rotate-right-add checksum of all eleven bytes;
// name_ok is the same on all eleven and is low for a name longer than
// MAX_NAME_LEN bytes or one holding a forbidden character. a base longer than
// eight bytes is cut to six plus '~1'. timing: name bytes are taken one per
// cycle; after the final byte the input stalls while the emit counter walks
// the eleven positions through a single output register. the next name's
// first byte is taken while the eleventh word still waits in the output
// register.
`default_nettype none

module short_name_generator_with_checksum_top #(
  parameter int unsigned MAX_NAME_LEN = sng_pkg::MaxNameLen
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave stream: name bytes
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] name_byte
  input  wire logic        s_tlast,   // last_byte
  // master stream: short name words
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [23:0] m_tdata,   // [7:0] short_byte, [11:8] byte_index,
                                      // [19:12] name_checksum, [20] name_ok
  output      logic        m_tlast    // final_result
);

  sng_pkg::sng_cmd_t  cmd;
  sng_pkg::sng_stat_t stat;

  logic [7:0] short_byte;
  logic [3:0] byte_index;
  logic [7:0] name_checksum;
  logic       name_ok;

  // sequencing: collect bytes, then walk the eleven output positions
  sng_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .m_tready (m_tready),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  // name state, short name formation, checksum and output register
  sng_datapath #(
    .MAX_NAME_LEN (MAX_NAME_LEN)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .m_tready      (m_tready),
    .name_byte     (s_tdata),
    .stat          (stat),
    .short_byte    (short_byte),
    .byte_index    (byte_index),
    .name_checksum (name_checksum),
    .name_ok       (name_ok),
    .final_result  (m_tlast),
    .out_valid     (m_tvalid)
  );

  // pack result fields, padded to whole bytes
  assign m_tdata = {3'b000, name_ok, name_checksum, byte_index, short_byte};

`ifndef SYNTH
  // input stalls right after the final name byte
  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input not stalled after final name byte");

  // tlast only on the eleventh position
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (byte_index == sng_pkg::IDX_LAST))
    else $error("tlast on wrong position");

  // checksum field is zero except on the final word
  a_sum_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (name_checksum == 8'h00))
    else $error("checksum on non-final word");

  // a taken word that is not the last is followed at once by the next position
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && byte_index == $past(byte_index) + 4'd1))
    else $error("short name positions out of sequence");
`endif

endmodule

`default_nettype wire
